// ----- sv/glbt_pkg.sv -----
// Shared types and constants for the generational buffer lease table.
package glbt_pkg;

    localparam int SLOTS_DEFAULT = 4;
    localparam int SLOTS_MAX     = 16;
    localparam int SLOT_IDX_W    = 4;
    localparam int GEN_W         = 32;
    localparam int CNT_W         = 32;
    localparam int LEASE_W       = 5;

    typedef enum logic [2:0] {
        OP_CLAIM   = 3'd0,
        OP_PUBLISH = 3'd1,
        OP_CANCEL  = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLOSE   = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_WRITING = 2'd1,
        ST_LEASED  = 2'd2
    } slot_st_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [7:0]       slot_index;
        logic [GEN_W-1:0] generation_tag;
    } req_t;

    typedef struct packed {
        logic                  accepted;
        logic [SLOT_IDX_W-1:0] granted_slot;
        logic [GEN_W-1:0]      granted_generation;
        logic [LEASE_W-1:0]    outstanding_leases;
        logic [CNT_W-1:0]      invalid_count;
        logic                  drained;
    } rsp_t;

    // Result of the lowest-free-slot search.
    typedef struct packed {
        logic                  found;
        logic [SLOT_IDX_W-1:0] slot;
    } pick_t;

endpackage

// ----- sv/glbt_claim_pick.sv -----
// Priority encoder: lowest free slot for a claim.
module glbt_claim_pick #(
    parameter int SLOTS = glbt_pkg::SLOTS_DEFAULT
) (
    input  logic [SLOTS-1:0] free_mask,
    output glbt_pkg::pick_t  pick
);

    always_comb
    begin
        pick = '0;
        // Scan high to low so the lowest free slot wins.
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                pick.found = 1'b1;
                pick.slot  = glbt_pkg::SLOT_IDX_W'(i);
            end
        end
    end

endmodule

// ----- sv/generational_buffer_lease_table_top.sv -----
// Top level of the generational buffer lease table.
//
// Usage:
//   Requests enter on the req channel (req_valid / req_stall / req) and each
//   request produces exactly one response item on the rsp channel
//   (rsp_valid / rsp_stall / rsp). An item moves when valid is high and
//   stall is low at a rising clock edge.
//   A request is captured in an input register; from there it is resolved
//   against the slot table and the response is registered in the result
//   register once that register can take it. One request can be accepted
//   every cycle while the receiver does not stall: the slot search is a
//   small priority encoder and every table update settles combinationally
//   within the resolve step.
//   When the receiver stalls, the response holds in its register and the
//   pending request waits in the input register; req_stall rises only when
//   both are full. The table changes only when a request is resolved.
//   Reset (rst_n low, asynchronous) frees all slots, zeroes generations,
//   the outstanding and invalid counters and the closing flag, and empties
//   both registers. A clear request does the same to the table in-band.
module generational_buffer_lease_table_top #(
    parameter int SLOTS = glbt_pkg::SLOTS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  glbt_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output glbt_pkg::rsp_t rsp
);

    localparam int OUT_W = $clog2(SLOTS + 1);
    localparam int GW    = glbt_pkg::GEN_W;
    localparam int CW    = glbt_pkg::CNT_W;

    // Slot table and counters.
    glbt_pkg::slot_st_t state_reg [SLOTS];
    glbt_pkg::slot_st_t state_next [SLOTS];
    logic [GW-1:0]      gen_reg [SLOTS];
    logic [GW-1:0]      gen_next [SLOTS];
    logic [OUT_W-1:0]   outst_reg, outst_next;
    logic [CW-1:0]      inval_reg, inval_next;
    logic               closing_reg, closing_next;

    // Input and result registers.
    logic               req_vld_reg;
    glbt_pkg::req_t     req_reg;
    logic               rsp_vld_reg;
    glbt_pkg::rsp_t     rsp_reg, rsp_next;

    logic               advance;
    logic [SLOTS-1:0]   free_mask;
    glbt_pkg::pick_t    pick;
    logic [SLOTS-1:0]   hit;
    logic               match_wr;
    logic               match_ls;
    logic [GW-1:0]      gen_sel;
    logic [GW-1:0]      gen_new;
    logic               inval_bump;
    logic               do_free;

    // Resolve when a request is held and the result register can take it.
    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            free_mask[i] = (state_reg[i] == glbt_pkg::ST_FREE);
        end
    end

    glbt_claim_pick #(
        .SLOTS(SLOTS)
    ) u_pick (
        .free_mask(free_mask),
        .pick     (pick)
    );

    // Slot lookup for publish, cancel and release; out of range never hits.
    always_comb
    begin
        match_wr = 1'b0;
        match_ls = 1'b0;
        gen_sel  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i] = (req_reg.slot_index == 8'(i));
            if (hit[i] && gen_reg[i] == req_reg.generation_tag)
            begin
                if (state_reg[i] == glbt_pkg::ST_WRITING)
                begin
                    match_wr = 1'b1;
                end
                if (state_reg[i] == glbt_pkg::ST_LEASED)
                begin
                    match_ls = 1'b1;
                end
            end
            if (pick.slot == glbt_pkg::SLOT_IDX_W'(i))
            begin
                gen_sel = gen_reg[i];
            end
        end
    end

    assign gen_new = gen_sel + GW'(1);

    always_comb
    begin
        state_next   = state_reg;
        gen_next     = gen_reg;
        outst_next   = outst_reg;
        closing_next = closing_reg;
        inval_bump   = 1'b0;
        do_free      = 1'b0;
        rsp_next     = '0;

        case (req_reg.operation)
            glbt_pkg::OP_CLAIM:
            begin
                if (!closing_reg && pick.found)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (pick.slot == glbt_pkg::SLOT_IDX_W'(i))
                        begin
                            state_next[i] = glbt_pkg::ST_WRITING;
                            gen_next[i]   = gen_new;
                        end
                    end
                    outst_next                  = outst_reg + OUT_W'(1);
                    rsp_next.accepted           = 1'b1;
                    rsp_next.granted_slot       = pick.slot;
                    rsp_next.granted_generation = gen_new;
                end
            end
            glbt_pkg::OP_PUBLISH:
            begin
                if (match_wr)
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (hit[i])
                        begin
                            state_next[i] = glbt_pkg::ST_LEASED;
                        end
                    end
                    rsp_next.accepted = 1'b1;
                end
                else
                begin
                    inval_bump = 1'b1;
                end
            end
            glbt_pkg::OP_CANCEL:
            begin
                do_free    = match_wr;
                inval_bump = !match_wr;
            end
            glbt_pkg::OP_RELEASE:
            begin
                do_free    = match_ls;
                inval_bump = !match_ls;
            end
            glbt_pkg::OP_CLOSE:
            begin
                closing_next      = 1'b1;
                rsp_next.accepted = 1'b1;
            end
            glbt_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    state_next[i] = glbt_pkg::ST_FREE;
                    gen_next[i]   = '0;
                end
                outst_next        = '0;
                closing_next      = 1'b0;
                rsp_next.accepted = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_free)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (hit[i])
                begin
                    state_next[i] = glbt_pkg::ST_FREE;
                end
            end
            if (outst_reg != '0)
            begin
                outst_next = outst_reg - OUT_W'(1);
            end
            rsp_next.accepted = 1'b1;
        end

        // Invalid counter saturates at all ones; clear zeroes it.
        if (req_reg.operation == glbt_pkg::OP_CLEAR)
        begin
            inval_next = '0;
        end
        else if (inval_bump && inval_reg != '1)
        begin
            inval_next = inval_reg + CW'(1);
        end
        else
        begin
            inval_next = inval_reg;
        end

        rsp_next.outstanding_leases = glbt_pkg::LEASE_W'(outst_next);
        rsp_next.invalid_count      = inval_next;
        rsp_next.drained            = closing_next && (outst_next == '0);
    end

    // Table state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                state_reg[i] <= glbt_pkg::ST_FREE;
                gen_reg[i]   <= '0;
            end
            outst_reg   <= '0;
            inval_reg   <= '0;
            closing_reg <= 1'b0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            outst_reg   <= outst_next;
            inval_reg   <= inval_next;
            closing_reg <= closing_next;
        end
    end

    // Handshake control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                req_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ----- tb/generational_buffer_lease_table_top_test.sv -----
// Testbench for the lease table: directed and random requests checked against a local table.
module generational_buffer_lease_table_top_test;

    localparam int TABLE_SLOTS  = glbt_pkg::SLOTS_DEFAULT;
    localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int DRAIN_CYCLES = 10;    // idle time after the last response, to catch extra responses
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
    localparam int REPORT_MAX   = 10;
    localparam int GW           = glbt_pkg::GEN_W;

    // Operation codes the block does not define; they must change nothing.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    glbt_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    glbt_pkg::rsp_t rsp;

    // Local copy of the lease table, advanced once per accepted request.
    glbt_pkg::slot_st_t           slot_phase [TABLE_SLOTS];
    logic [GW-1:0]                slot_gen [TABLE_SLOTS];
    logic [glbt_pkg::LEASE_W-1:0] lease_count;
    logic [glbt_pkg::CNT_W-1:0]   reject_count;
    bit                           closing;

    // Responses owed by the block, oldest first.
    glbt_pkg::rsp_t pending_outcomes [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_hold     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    generational_buffer_lease_table_top #(
        .SLOTS (TABLE_SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Table prediction
    // ------------------------------------------------------------------

    function automatic void clear_table();
        foreach (slot_phase[i])
        begin
            slot_phase[i] = glbt_pkg::ST_FREE;
            slot_gen[i]   = '0;
        end
        lease_count  = '0;
        reject_count = '0;
        closing      = 1'b0;
    endfunction

    // Invalid counter sticks at all ones.
    function automatic void note_reject();
        if (reject_count != '1)
            reject_count++;
    endfunction

    // Slot exists, sits in the wanted state and carries the requester's tag.
    function automatic bit lease_holds(glbt_pkg::req_t r, glbt_pkg::slot_st_t want);
        if (int'(r.slot_index) >= TABLE_SLOTS)
            return 1'b0;
        return slot_phase[r.slot_index] == want
            && slot_gen[r.slot_index] == r.generation_tag;
    endfunction

    function automatic void drop_lease(int idx);
        slot_phase[idx] = glbt_pkg::ST_FREE;
        if (lease_count != '0)
            lease_count--;
    endfunction

    function automatic glbt_pkg::rsp_t resolve_lease_request(glbt_pkg::req_t r);
        glbt_pkg::rsp_t o;
        o = '0;
        case (r.operation)
            glbt_pkg::OP_CLAIM:
            begin
                // Lowest free slot wins; refused while closing or full.
                if (!closing)
                begin
                    for (int i = 0; i < TABLE_SLOTS; i++)
                    begin
                        if (!o.accepted && slot_phase[i] == glbt_pkg::ST_FREE)
                        begin
                            slot_phase[i]        = glbt_pkg::ST_WRITING;
                            slot_gen[i]          = slot_gen[i] + GW'(1);
                            lease_count++;
                            o.accepted           = 1'b1;
                            o.granted_slot       = glbt_pkg::SLOT_IDX_W'(i);
                            o.granted_generation = slot_gen[i];
                        end
                    end
                end
            end
            glbt_pkg::OP_PUBLISH:
            begin
                if (lease_holds(r, glbt_pkg::ST_WRITING))
                begin
                    slot_phase[r.slot_index] = glbt_pkg::ST_LEASED;
                    o.accepted = 1'b1;
                end
                else
                    note_reject();
            end
            glbt_pkg::OP_CANCEL:
            begin
                if (lease_holds(r, glbt_pkg::ST_WRITING))
                begin
                    drop_lease(int'(r.slot_index));
                    o.accepted = 1'b1;
                end
                else
                    note_reject();
            end
            glbt_pkg::OP_RELEASE:
            begin
                if (lease_holds(r, glbt_pkg::ST_LEASED))
                begin
                    drop_lease(int'(r.slot_index));
                    o.accepted = 1'b1;
                end
                else
                    note_reject();
            end
            glbt_pkg::OP_CLOSE:
            begin
                closing    = 1'b1;
                o.accepted = 1'b1;
            end
            glbt_pkg::OP_CLEAR:
            begin
                clear_table();
                o.accepted = 1'b1;
            end
            default:
            begin
                // spare codes: no effect, not accepted
            end
        endcase
        o.outstanding_leases = lease_count;
        o.invalid_count      = reject_count;
        o.drained            = closing && lease_count == '0;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Called at a falling edge with req_valid low; returns the same way.
    task automatic send_request(input glbt_pkg::req_t item);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req       = item;
        req_valid = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        pending_outcomes.push_back(resolve_lease_request(item));
        @(negedge clk);
        req_valid = 1'b0;
    endtask

    task automatic wait_all_returned();
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    function automatic glbt_pkg::req_t lease_req(logic [2:0] op, logic [7:0] idx,
                                                 logic [GW-1:0] tag);
        glbt_pkg::req_t r;
        r.operation      = op;
        r.slot_index     = idx;
        r.generation_tag = tag;
        return r;
    endfunction

    // Random slot currently in the given state, if any.
    function automatic bit pick_slot(glbt_pkg::slot_st_t want, output int idx);
        int hits [$];
        foreach (slot_phase[i])
            if (slot_phase[i] == want)
                hits.push_back(i);
        if (hits.size() == 0)
            return 1'b0;
        idx = hits[$urandom_range(hits.size() - 1)];
        return 1'b1;
    endfunction

    // Mostly well-formed lease traffic, some broken requests and raw noise.
    function automatic glbt_pkg::req_t random_request();
        glbt_pkg::req_t     r;
        int                 roll;
        int                 idx;
        glbt_pkg::slot_st_t want;
        r.operation      = glbt_pkg::OP_CLAIM;
        r.slot_index     = 8'($urandom_range(255));
        r.generation_tag = $urandom;
        roll             = int'($urandom_range(99));
        want             = glbt_pkg::ST_WRITING;
        if (roll < 28)
            r.operation = glbt_pkg::OP_CLAIM;
        else if (roll < 70)
        begin
            if (roll < 48)
            begin
                r.operation = glbt_pkg::OP_PUBLISH;
                want        = glbt_pkg::ST_WRITING;
            end
            else if (roll < 58)
            begin
                r.operation = glbt_pkg::OP_CANCEL;
                want        = glbt_pkg::ST_WRITING;
            end
            else
            begin
                r.operation = glbt_pkg::OP_RELEASE;
                want        = glbt_pkg::ST_LEASED;
            end
            if (pick_slot(want, idx))
            begin
                r.slot_index     = 8'(idx);
                r.generation_tag = slot_gen[idx];
            end
        end
        else if (roll < 84)
        begin
            // real slot, possibly wrong state, sometimes a tag one bit off
            r.operation      = 3'($urandom_range(glbt_pkg::OP_PUBLISH, glbt_pkg::OP_RELEASE));
            idx              = int'($urandom_range(TABLE_SLOTS - 1));
            r.slot_index     = 8'(idx);
            r.generation_tag = slot_gen[idx];
            if ($urandom_range(1))
                r.generation_tag ^= GW'(1) << $urandom_range(GW - 1);
        end
        else if (roll < 94)
            r.operation = 3'($urandom_range(7));
        else if (roll < 96)
            r.operation = glbt_pkg::OP_CLOSE;
        else
            r.operation = glbt_pkg::OP_CLEAR;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    // Receiver stall: a counted hold-off when asked, random otherwise.
    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            rsp_stall = 1'b1;
            recv_hold--;
        end
        else
            rsp_stall = ($urandom_range(99) < recv_idle_pct);
    end

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        glbt_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result with nothing outstanding: %h", rsp);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                compare_field("accepted", 64'(want.accepted), 64'(rsp.accepted));
                compare_field("granted_slot", 64'(want.granted_slot),
                              64'(rsp.granted_slot));
                compare_field("granted_generation", 64'(want.granted_generation),
                              64'(rsp.granted_generation));
                compare_field("outstanding_leases", 64'(want.outstanding_leases),
                              64'(rsp.outstanding_leases));
                compare_field("invalid_count", 64'(want.invalid_count),
                              64'(rsp.invalid_count));
                compare_field("drained", 64'(want.drained), 64'(rsp.drained));
            end
        end
    end

    // Watchdog: too long with no item moving either way.
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill, refuse, every mismatch flavor, spare codes, close, drain, clear.
    task automatic test_directed_ops();
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // slot 0
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // slot 1
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'hFF, 32'hFFFF_FFFF));   // ignored fields
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // slot 3
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // table full
        send_request(lease_req(glbt_pkg::OP_PUBLISH, 8'd0, 32'd1));
        send_request(lease_req(glbt_pkg::OP_PUBLISH, 8'd0, 32'd1));          // already leased
        send_request(lease_req(glbt_pkg::OP_PUBLISH, 8'd1, 32'hFFFF_FFFF));  // stale tag
        send_request(lease_req(glbt_pkg::OP_PUBLISH, 8'(TABLE_SLOTS), 32'd1)); // past the end
        send_request(lease_req(glbt_pkg::OP_RELEASE, 8'hFF, 32'd1));         // far out of range
        send_request(lease_req(glbt_pkg::OP_CANCEL, 8'd1, 32'd1));
        send_request(lease_req(glbt_pkg::OP_CANCEL, 8'd0, 32'd1));           // leased, not writing
        send_request(lease_req(glbt_pkg::OP_RELEASE, 8'd0, 32'd1));
        send_request(lease_req(glbt_pkg::OP_RELEASE, 8'd0, 32'd1));          // now free
        send_request(lease_req(OP_SPARE_LO, 8'd2, 32'd1));
        send_request(lease_req(OP_SPARE_HI, 8'hFF, 32'hFFFF_FFFF));
        send_request(lease_req(glbt_pkg::OP_CLOSE, 8'hFF, 32'hFFFF_FFFF));
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // refused, closing
        send_request(lease_req(glbt_pkg::OP_CANCEL, 8'd2, 32'd1));
        send_request(lease_req(glbt_pkg::OP_PUBLISH, 8'd3, 32'd1));
        send_request(lease_req(glbt_pkg::OP_RELEASE, 8'd3, 32'd1));          // last lease: drained
        send_request(lease_req(glbt_pkg::OP_CLOSE, 8'd0, 32'd0));            // repeat close
        send_request(lease_req(glbt_pkg::OP_CLEAR, 8'hFF, 32'hFFFF_FFFF));
        send_request(lease_req(glbt_pkg::OP_CLAIM, 8'd0, 32'd0));            // generation restarts
        wait_all_returned();
    endtask

    task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_request(random_request());
        wait_all_returned();
    endtask

    // Receiver holds off while the sender keeps offering, so both
    // registers fill and req_stall must rise; then everything drains.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold     = HOLD_CYCLES;
        repeat (24)
            send_request(random_request());
        wait_all_returned();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 85;
        clear_table();
        repeat (4)
            @(negedge clk);
        rst_n = 1'b1;

        test_directed_ops();
        test_random_traffic(270, 9, 85);
        test_random_traffic(270, 85, 9);
        test_backpressure();
        test_random_traffic(270, 0, 0);

        // anything extra from the block shows up here
        repeat (DRAIN_CYCLES)
            @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- files.f -----
sv/glbt_pkg.sv
sv/glbt_claim_pick.sv
sv/generational_buffer_lease_table_top.sv
tb/generational_buffer_lease_table_top_test.sv
